// ===== sv/hgs_pkg.sv =====
package hgs_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int NEWTON_STEPS = 6;
   localparam logic [63:0] BASE_RESET = 64'd1025;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int ERR_OVERFLOW_BIT = 0;
   localparam int ERR_EMPTY_BIT = 1;

   typedef enum logic [1:0] {
      KIND_PUSH,
      KIND_POP,
      KIND_PEEK,
      KIND_VERIFY
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] top_value;
      logic [10:0]        depth_used;
      logic [1:0]         error_flags;
      logic [63:0]        running_hash;
      logic               hash_ok;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NEWT_BX,
      ST_NEWT_SET,
      ST_NEWT_XT,
      ST_NEWT_CHK,
      ST_PUSH_MUL,
      ST_POP_RD,
      ST_POP_MUL,
      ST_HASH_WB,
      ST_PEEK_RD,
      ST_VER_RD,
      ST_VER_MUL,
      ST_VER_NEXT,
      ST_RESP
   } hgs_state_type;

   // elaboration only: inverse of an odd base mod 2^64
   function automatic logic [63:0] odd_inverse(input logic [63:0] b);
      logic [63:0] x;
      x = 64'd1;
      for (int i = 0; i < NEWTON_STEPS; i++) begin
         x = x * (64'd2 - b * x);
      end
      return x;
   endfunction

   localparam logic [63:0] INV_RESET = odd_inverse(BASE_RESET);

   function automatic logic [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

endpackage

// ===== sv/hash_guarded_stack.sv =====
// Peek reads the top entry; push runs one 64-bit multiply; pop reads, then multiplies. An
// overflowing push or an empty pop, peek or verify goes straight to its result; verify reads
// and multiplies once per stored entry. The next item is accepted only after the result is
// taken. The 64-bit multiply is three passes of one shared 32x32 multiplier; the entry store has
// one registered read port. A base write busies the block for six two-multiply Newton steps.
// Reset (synchronous, active high): empty stack, hash and sticky flags zero, base 1025 with its
// inverse preloaded; stored entries are not cleared.
module hash_guarded_stack #(
   parameter int DEPTH = hgs_pkg::DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  hgs_pkg::req_type req_item,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output hgs_pkg::rsp_type rsp_item,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [63:0]     csr_data
);
   import hgs_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(NEWTON_STEPS);

   hgs_state_type state_ff, state_in;

   logic [CW-1:0]      fill_ff, fill_in;
   logic [63:0]        hash_ff, hash_in;
   logic [63:0]        base_ff, base_in;
   logic [63:0]        inv_ff, inv_in;
   logic [1:0]         sticky_ff, sticky_in;
   logic [1:0]         status_ff, status_in;
   logic signed [31:0] top_ff, top_in;
   logic               ok_ff, ok_in;
   logic [IW-1:0]      iter_ff, iter_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [63:0]        vh_ff, vh_in;

   // shared multiply unit
   logic [63:0] mul_a_ff, mul_a_in;
   logic [63:0] mul_b_ff, mul_b_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [1:0]  mstep_ff, mstep_in;
   logic [31:0] mul_x, mul_y;
   logic        mul_active, mul_done;

   // entry store
   logic [31:0] mem [DEPTH];
   logic        wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0] rd_data_ff;

   logic req_fire, csr_fire, rsp_fire, is_full, is_empty, last_iter;
   logic [CW+10:0] depth_ext;

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign is_full   = (fill_ff == CW'(DEPTH));
   assign is_empty  = (fill_ff == '0);
   assign last_iter = (iter_ff == IW'(NEWTON_STEPS - 1));

   assign mul_active = (state_ff == ST_NEWT_BX) || (state_ff == ST_NEWT_XT) ||
                       (state_ff == ST_PUSH_MUL) || (state_ff == ST_POP_MUL) ||
                       (state_ff == ST_VER_MUL);
   assign mul_done   = mul_active && (mstep_ff == 2'd3);

   always_comb begin
      unique case (mstep_ff)
         2'd1: begin
            mul_x = mul_a_ff[31:0];
            mul_y = mul_b_ff[63:32];
         end
         2'd2: begin
            mul_x = mul_a_ff[63:32];
            mul_y = mul_b_ff[31:0];
         end
         default: begin
            mul_x = mul_a_ff[31:0];
            mul_y = mul_b_ff[31:0];
         end
      endcase
   end

   assign prod_in  = mul_x * mul_y;
   assign mstep_in = mul_active ? mstep_ff + 2'd1 : 2'd0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               state_in = ST_NEWT_BX;
            end else if (req_fire) begin
               unique case (req_item.kind)
                  KIND_PUSH:   state_in = is_full  ? ST_RESP : ST_PUSH_MUL;
                  KIND_POP:    state_in = is_empty ? ST_RESP : ST_POP_RD;
                  KIND_PEEK:   state_in = is_empty ? ST_RESP : ST_PEEK_RD;
                  KIND_VERIFY: state_in = is_empty ? ST_RESP : ST_VER_RD;
               endcase
            end
         end
         ST_NEWT_BX:  if (mul_done) state_in = ST_NEWT_SET;
         ST_NEWT_SET: state_in = ST_NEWT_XT;
         ST_NEWT_XT:  if (mul_done) state_in = ST_NEWT_CHK;
         ST_NEWT_CHK: state_in = last_iter ? ST_IDLE : ST_NEWT_BX;
         ST_PUSH_MUL: if (mul_done) state_in = ST_HASH_WB;
         ST_POP_RD:   state_in = ST_POP_MUL;
         ST_POP_MUL:  if (mul_done) state_in = ST_HASH_WB;
         ST_HASH_WB:  state_in = ST_RESP;
         ST_PEEK_RD:  state_in = ST_RESP;
         ST_VER_RD:   state_in = ST_VER_MUL;
         ST_VER_MUL:  if (mul_done) state_in = ST_VER_NEXT;
         ST_VER_NEXT: state_in = (idx_ff == fill_ff) ? ST_RESP : ST_VER_RD;
         ST_RESP:     if (rsp_fire) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      fill_in   = fill_ff;
      hash_in   = hash_ff;
      base_in   = base_ff;
      inv_in    = inv_ff;
      sticky_in = sticky_ff;
      status_in = status_ff;
      top_in    = top_ff;
      ok_in     = ok_ff;
      iter_in   = iter_ff;
      idx_in    = idx_ff;
      vh_in     = vh_ff;
      mul_a_in  = mul_a_ff;
      mul_b_in  = mul_b_ff;
      acc_in    = acc_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = fill_ff[AW-1:0];
      rd_addr   = idx_ff[AW-1:0];

      unique case (mstep_ff)
         2'd1:    if (mul_active) acc_in = acc_ff + prod_ff;
         2'd2,
         2'd3:    if (mul_active) acc_in = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
         default: ;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               base_in  = csr_data | 64'd1;
               inv_in   = 64'd1;
               iter_in  = '0;
               mul_a_in = csr_data | 64'd1;
               mul_b_in = 64'd1;
               acc_in   = '0;
            end else if (req_fire) begin
               status_in = STATUS_OK;
               top_in    = '0;
               ok_in     = 1'b1;
               unique case (req_item.kind)
                  KIND_PUSH: begin
                     if (is_full) begin
                        status_in = STATUS_OVERFLOW;
                        sticky_in[ERR_OVERFLOW_BIT] = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        fill_in  = fill_ff + CW'(1);
                        mul_a_in = hash_ff;
                        mul_b_in = base_ff;
                        acc_in   = sext32(req_item.value);
                     end
                  end
                  KIND_POP, KIND_PEEK: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                        sticky_in[ERR_EMPTY_BIT] = 1'b1;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(fill_ff - CW'(1));
                        if (req_item.kind == KIND_POP) begin
                           fill_in = fill_ff - CW'(1);
                        end
                     end
                  end
                  KIND_VERIFY: begin
                     if (is_empty) begin
                        ok_in = (hash_ff == 64'd0);
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        idx_in  = CW'(1);
                        vh_in   = '0;
                     end
                  end
               endcase
            end
         end
         ST_NEWT_SET: begin
            mul_a_in = inv_ff;
            mul_b_in = 64'd2 - acc_ff;
            acc_in   = '0;
         end
         ST_NEWT_CHK: begin
            inv_in   = acc_ff;
            iter_in  = iter_ff + IW'(1);
            mul_a_in = base_ff;
            mul_b_in = acc_ff;
            acc_in   = '0;
         end
         ST_POP_RD: begin
            mul_a_in = hash_ff - sext32(rd_data_ff);
            mul_b_in = inv_ff;
            acc_in   = '0;
         end
         ST_HASH_WB: hash_in = acc_ff;
         ST_PEEK_RD: top_in = rd_data_ff;
         ST_VER_RD: begin
            mul_a_in = vh_ff;
            mul_b_in = base_ff;
            acc_in   = sext32(rd_data_ff);
         end
         ST_VER_NEXT: begin
            vh_in = acc_ff;
            if (idx_ff == fill_ff) begin
               ok_in = (acc_ff == hash_ff);
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         hash_ff   <= '0;
         base_ff   <= BASE_RESET;
         inv_ff    <= INV_RESET;
         sticky_ff <= '0;
         mstep_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         hash_ff   <= hash_in;
         base_ff   <= base_in;
         inv_ff    <= inv_in;
         sticky_ff <= sticky_in;
         mstep_ff  <= mstep_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      top_ff    <= top_in;
      ok_ff     <= ok_in;
      iter_ff   <= iter_in;
      idx_ff    <= idx_in;
      vh_ff     <= vh_in;
      mul_a_ff  <= mul_a_in;
      mul_b_ff  <= mul_b_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_item.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign depth_ext = {11'b0, fill_ff};

   always_comb begin
      rsp_item.status       = status_ff;
      rsp_item.top_value    = top_ff;
      rsp_item.depth_used   = depth_ext[10:0];
      rsp_item.error_flags  = sticky_ff;
      rsp_item.running_hash = hash_ff;
      rsp_item.hash_ok      = ok_ff;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("accepted a second item while busy");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count beyond depth");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status_ff == STATUS_OVERFLOW) |-> sticky_ff[ERR_OVERFLOW_BIT])
      else $error("overflow reported without sticky flag");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_empty && (req_item.kind == KIND_POP) |=>
         rsp_valid && (status_ff == STATUS_EMPTY))
      else $error("pop on empty stack not reported");

   a_mstep_idle: assert property (@(posedge clock) disable iff (reset)
      !mul_active |-> (mstep_ff == 2'd0))
      else $error("multiply step counter running outside multiply");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import hgs_pkg::*;

   localparam int STACK_DEPTH = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 500_000;
   localparam int HOLD_AT_RESULT = 40;
   localparam int HOLD_CYCLES = 300;

   typedef enum logic [1:0] {
      RX_STREAM,
      RX_COIN,
      RX_SPARSE
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [63:0] csr_data = '0;

   hash_guarded_stack #(.DEPTH(STACK_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // shadow copy of the stack
   logic [31:0] shadow_words [STACK_DEPTH];
   int          shadow_fill = 0;
   logic [63:0] shadow_hash = '0;
   logic [63:0] shadow_base = BASE_RESET;
   logic [63:0] shadow_inv;
   logic [1:0]  shadow_sticky = '0;

   req_type ops_to_send[$];
   rsp_type stack_results_due[$];

   int fault_count = 0;
   int results_seen = 0;
   int ops_sent = 0;
   int base_writes = 0;
   int peak_fill = 0;
   int overflow_hits = 0;
   int empty_hits = 0;
   int hash_mismatches = 0;

   function automatic logic [63:0] newton_inverse(input logic [63:0] b);
      logic [63:0] x;
      x = 64'd1;
      repeat (NEWTON_STEPS) x = x * (64'd2 - b * x);
      return x;
   endfunction

   task automatic set_hash_base(input logic [63:0] v);
      shadow_base = v | 64'd1;
      shadow_inv = newton_inverse(shadow_base);
      base_writes++;
   endtask

   task automatic apply_stack_op(input req_type op);
      rsp_type     r;
      logic [63:0] rehash;
      logic [31:0] top;
      r = '0;
      r.status = STATUS_OK;
      r.hash_ok = 1'b1;
      ops_sent++;
      case (op.kind)
         KIND_PUSH: begin
            if (shadow_fill >= STACK_DEPTH) begin
               r.status = STATUS_OVERFLOW;
               shadow_sticky[ERR_OVERFLOW_BIT] = 1'b1;
               overflow_hits++;
            end else begin
               shadow_words[shadow_fill] = op.value;
               shadow_hash = shadow_hash * shadow_base + {{32{op.value[31]}}, op.value};
               shadow_fill++;
               if (shadow_fill > peak_fill) peak_fill = shadow_fill;
            end
         end
         KIND_POP, KIND_PEEK: begin
            if (shadow_fill == 0) begin
               r.status = STATUS_EMPTY;
               shadow_sticky[ERR_EMPTY_BIT] = 1'b1;
               empty_hits++;
            end else begin
               top = shadow_words[shadow_fill - 1];
               if (op.kind == KIND_POP) begin
                  shadow_hash = (shadow_hash - {{32{top[31]}}, top}) * shadow_inv;
                  shadow_fill--;
               end else begin
                  r.top_value = top;
               end
            end
         end
         default: begin
            rehash = '0;
            for (int i = 0; i < shadow_fill; i++) begin
               rehash = rehash * shadow_base
                  + {{32{shadow_words[i][31]}}, shadow_words[i]};
            end
            r.hash_ok = (rehash == shadow_hash);
            if (!r.hash_ok) hash_mismatches++;
         end
      endcase
      r.depth_used = 11'(shadow_fill);
      r.error_flags = shadow_sticky;
      r.running_hash = shadow_hash;
      stack_results_due.push_back(r);
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fault_count++;
      end
   endfunction

   // sender: bursts with random gaps
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) apply_stack_op(req_item);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (ops_to_send.size() > 0) begin
               req_valid <= 1'b1;
               req_item <= ops_to_send.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks results, stalls on its own pattern
   rx_mode_type rx_mode = RX_STREAM;
   int          mode_left;
   int          hold_left;
   rsp_type     want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         mode_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (stack_results_due.size() == 0) begin
               $error("result item with no pending operation");
               fault_count++;
            end else begin
               want = stack_results_due.pop_front();
               check_field("status", want.status, rsp_item.status);
               check_field("top_value", want.top_value, rsp_item.top_value);
               check_field("depth_used", want.depth_used, rsp_item.depth_used);
               check_field("error_flags", want.error_flags, rsp_item.error_flags);
               check_field("running_hash", want.running_hash, rsp_item.running_hash);
               check_field("hash_ok", want.hash_ok, rsp_item.hash_ok);
            end
            if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 120);
            end else begin
               mode_left--;
            end
            case (rx_mode)
               RX_STREAM: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               default:   rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic queue_op(input kind_type k, input logic [31:0] v);
      req_type op;
      op.kind = k;
      op.value = v;
      ops_to_send.push_back(op);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 15));
         3: return -32'($urandom_range(1, 16));
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_random_ops(input int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) queue_op(KIND_PUSH, pick_word());
         else if (pick < 70) queue_op(KIND_POP, $urandom());
         else if (pick < 85) queue_op(KIND_PEEK, $urandom());
         else queue_op(KIND_VERIFY, $urandom());
      end
   endtask

   task automatic wait_stack_quiet();
      do @(negedge clock);
      while (ops_to_send.size() != 0 || req_valid || stack_results_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_base(input logic [63:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock);
      while (!csr_ready);
      set_hash_base(v);
      csr_valid <= 1'b0;
   endtask

   int cycle_count = 0;

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int unwind;
      shadow_inv = newton_inverse(shadow_base);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty accesses, word extremes, every kind
      queue_op(KIND_POP, 32'h0);
      queue_op(KIND_PEEK, 32'hFFFF_FFFF);
      queue_op(KIND_VERIFY, 32'h0);
      queue_op(KIND_PUSH, 32'h7FFF_FFFF);
      queue_op(KIND_PUSH, 32'h8000_0000);
      queue_op(KIND_PUSH, 32'hFFFF_FFFF);
      queue_op(KIND_PUSH, 32'h0);
      queue_op(KIND_PUSH, 32'h1);
      queue_op(KIND_PEEK, 32'h0);
      queue_op(KIND_VERIFY, 32'h0);
      queue_op(KIND_POP, 32'h0);
      queue_op(KIND_PEEK, 32'h0);
      queue_op(KIND_POP, 32'h0);
      queue_op(KIND_PUSH, 32'h5555_5555);
      queue_op(KIND_PUSH, 32'hAAAA_AAAA);
      queue_op(KIND_VERIFY, 32'h0);
      repeat (6) queue_op(KIND_POP, 32'h0);
      queue_op(KIND_PEEK, 32'h0);
      queue_op(KIND_VERIFY, 32'h0);
      wait_stack_quiet();

      write_base(64'h0);
      queue_random_ops(66);
      wait_stack_quiet();

      write_base('1);
      queue_random_ops(66);
      repeat (4) queue_op(KIND_PUSH, pick_word());
      wait_stack_quiet();

      // base change with words stored: hash kept, verify may disagree
      write_base({$urandom(), $urandom()} & ~64'd1);
      queue_op(KIND_VERIFY, 32'h0);
      queue_op(KIND_POP, 32'h0);
      queue_op(KIND_VERIFY, 32'h0);
      queue_random_ops(66);
      wait_stack_quiet();

      // deep run of pushes, then unwind past empty
      write_base(64'h8000_0000_0000_0001);
      repeat (40) queue_op(KIND_PUSH, pick_word());
      queue_op(KIND_PEEK, 32'h0);
      queue_op(KIND_VERIFY, 32'h0);
      unwind = shadow_fill + 40 + 2;
      repeat (unwind) queue_op(KIND_POP, 32'h0);
      queue_op(KIND_PEEK, 32'h0);
      queue_op(KIND_VERIFY, 32'h0);
      wait_stack_quiet();

      write_base(64'd3);
      queue_random_ops(66);
      wait_stack_quiet();

      write_base({$urandom(), $urandom()});
      queue_random_ops(66);
      wait_stack_quiet();
      repeat (20) @(posedge clock);

      if (stack_results_due.size() != 0) begin
         $error("%0d expected results never arrived", stack_results_due.size());
         fault_count++;
      end
      $display("Ran %0d stack ops, %0d results, %0d base writes, peak depth %0d.",
               ops_sent, results_seen, base_writes, peak_fill);
      $display("Overflow pushes %0d, empty accesses %0d, verify mismatches %0d.",
               overflow_hits, empty_hits, hash_mismatches);
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
